/* sv/pbms_pkg.sv */
`default_nettype none
package pbms_pkg;

  localparam int COORD_W    = 24;
  localparam int IDX_W      = 7;
  localparam int RANGE_W    = 24;
  localparam int COUNT_W    = 8;
  localparam int CFG_DATA_W = 32;
  localparam int PADDR_W    = 3;

  // cordic vector, angle accumulator, square root and square widths
  localparam int CW = 57;
  localparam int ZW = 35;
  localparam int RW = 49;
  localparam int MW = 48;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int SQ_FIRST     = 3;
  localparam int SQRT_STEPS   = 24;
  localparam int SQ_SHIFT0    = 46 + 2 * SQ_FIRST;

  localparam logic OP_READ = 1'b1;

  localparam logic REG_BEAM_COUNT = 1'b0;
  localparam logic REG_MAX_RANGE  = 1'b1;

  localparam logic [COUNT_W-1:0] BEAM_COUNT_RST = 8'd120;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = 24'd20480;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] TURN_ATAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic              load;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              ang;
    logic              mul;
    logic              look;
    logic              upd;
    logic              rlook;
    logic              rd_out;
  } pbms_cmd_t;

endpackage
`default_nettype wire

/* sv/pbms_in_if.sv */
`default_nettype none
interface pbms_in_if;
  import pbms_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic [IDX_W-1:0]          beam_index;

  modport source (output valid, output op, output x, output y, output beam_index,
                  input ready);
  modport sink (input valid, input op, input x, input y, input beam_index,
                output ready);
endinterface
`default_nettype wire

/* sv/pbms_out_if.sv */
`default_nettype none
interface pbms_out_if;
  import pbms_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] beam_range;
  logic               beam_hit;

  modport source (output valid, output beam_range, output beam_hit, input ready);
  modport sink (input valid, input beam_range, input beam_hit, output ready);
endinterface
`default_nettype wire

/* sv/pbms_regs.sv */
`default_nettype none
module pbms_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pbms_pkg::PADDR_W-1:0]       paddr,
  input  logic [pbms_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pbms_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [pbms_pkg::COUNT_W-1:0]       beam_count,
  output logic [pbms_pkg::RANGE_W-1:0]       max_range
);
  import pbms_pkg::*;

  logic [COUNT_W-1:0] beam_count_r;
  logic [RANGE_W-1:0] max_range_r;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_count_r <= BEAM_COUNT_RST;
      max_range_r  <= MAX_RANGE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BEAM_COUNT: beam_count_r <= pwdata[COUNT_W-1:0];
        REG_MAX_RANGE:  max_range_r  <= pwdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BEAM_COUNT: prdata = CFG_DATA_W'(beam_count_r);
      REG_MAX_RANGE:  prdata = CFG_DATA_W'(max_range_r);
      default:        prdata = '0;
    endcase
  end

  assign beam_count = beam_count_r;
  assign max_range  = max_range_r;
endmodule
`default_nettype wire

/* sv/pbms_ctrl.sv */
`default_nettype none
module pbms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic                out_free,
  output logic                in_ready,
  output pbms_pkg::pbms_cmd_t cmd
);
  import pbms_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ITER  = 3'd1;
  localparam logic [2:0] S_ANG   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_RLOOK = 3'd6;
  localparam logic [2:0] S_RDOUT = 3'd7;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = (in_op == OP_READ) ? S_RLOOK : S_ITER;
        end
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (step_r == LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = S_ANG;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_ANG: begin
        cmd.ang   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RLOOK: begin
        cmd.rlook = 1'b1;
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        // hold until the result register can take the beat
        if (out_free) begin
          cmd.rd_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ITER |-> step_r <= LAST_STEP)
    else $error("cordic step counter ran past the last step");

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDOUT && out_free) |=> state_r == S_IDLE)
    else $error("read result not handed off when output was free");
endmodule
`default_nettype wire

/* sv/pbms_dp.sv */
`default_nettype none
module pbms_dp #(
  parameter int MAX_BEAMS  = 128,
  parameter int ANGLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pbms_pkg::pbms_cmd_t                cmd,
  input  logic signed [pbms_pkg::COORD_W-1:0] x,
  input  logic signed [pbms_pkg::COORD_W-1:0] y,
  input  logic [pbms_pkg::IDX_W-1:0]         beam_index,
  input  logic [pbms_pkg::COUNT_W-1:0]       beam_count,
  input  logic [pbms_pkg::RANGE_W-1:0]       max_range,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pbms_pkg::RANGE_W-1:0]       out_beam_range,
  output logic                               out_beam_hit,
  output logic                               out_free
);
  import pbms_pkg::*;

  localparam int BW = $clog2(MAX_BEAMS);
  localparam int NW = $clog2(MAX_BEAMS + 1);
  localparam int AW = ANGLE_BITS + 1;
  localparam int PW = AW + NW;

  localparam logic signed [ZW-1:0] QUARTER = 35'sh040000000;
  localparam logic signed [ZW-1:0] HALF    = 35'sh080000000;
  localparam logic [32:0]          FULL    = 33'h100000000;
  localparam logic [33:0]          ROUND   = 34'(64'd1 << (31 - ANGLE_BITS));

  // captured item
  logic signed [COORD_W-1:0] x_r, y_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      origin_r;

  // cordic
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] z_r;

  // squares and square root
  logic signed [MW-1:0] prod_r;
  logic [RW-1:0]        rem_r, root_r;

  // beam select
  logic [AW-1:0]  a_r;
  logic [PW-1:0]  mprod_r;
  logic [BW-1:0]  addr_r;
  logic           vbit_r;

  // beam store
  logic [RANGE_W-1:0]   mem_r [MAX_BEAMS];
  logic [RANGE_W-1:0]   rdata_r;
  logic [MAX_BEAMS-1:0] valid_r;

  // result register
  logic               out_valid_r;
  logic [RANGE_W-1:0] out_range_r;
  logic               out_hit_r;

  logic signed [COORD_W:0] xs, ys, xq, yq;
  logic signed [ZW-1:0]    zq;
  logic signed [CW-1:0]    dx, dy;
  logic signed [ZW-1:0]    tz;
  logic signed [COORD_W-1:0] mop;
  logic [5:0]              sq_sh;
  logic [RW-1:0]           sq_bit, sq_trial;
  logic                    sq_act;
  logic signed [ZW-1:0]    zf;
  logic [32:0]             zc;
  logic [33:0]             zr;
  logic [AW-1:0]           a_nxt;
  logic [NW-1:0]           n_eff;
  logic [NW-1:0]           bfull;
  logic [BW-1:0]           bsel;
  logic [31:0]             idx_wide;
  logic [BW-1:0]           idx_addr;
  logic                    idx_ok;
  logic [BW-1:0]           rd_addr;
  logic                    upd_we;

  // quadrant fold into the right half plane
  always_comb begin
    xs = {x[COORD_W-1], x};
    ys = {y[COORD_W-1], y};
    if (xs < 0 && ys >= 0) begin
      xq = ys;
      yq = -xs;
      zq = QUARTER;
    end else if (xs < 0) begin
      xq = -ys;
      yq = xs;
      zq = -QUARTER;
    end else begin
      xq = xs;
      yq = ys;
      zq = '0;
    end
  end

  assign dx = cy_r >>> cmd.step;
  assign dy = cx_r >>> cmd.step;
  assign tz = $signed({{(ZW-32){1'b0}}, TURN_ATAN[cmd.step]});

  assign mop      = (cmd.step == '0) ? x_r : y_r;
  assign sq_sh    = 6'(SQ_SHIFT0) - {cmd.step, 1'b0};
  assign sq_bit   = RW'(1) << sq_sh;
  assign sq_trial = root_r + sq_bit;
  assign sq_act   = (cmd.step >= STEP_W'(SQ_FIRST)) &&
                    (cmd.step < STEP_W'(SQ_FIRST + SQRT_STEPS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= x;
      y_r      <= y;
      idx_r    <= beam_index;
      origin_r <= (x == '0) && (y == '0);
      cx_r     <= {{(CW-COORD_W-31){xq[COORD_W]}}, xq, {30{1'b0}}};
      cy_r     <= {{(CW-COORD_W-31){yq[COORD_W]}}, yq, {30{1'b0}}};
      z_r      <= zq;
      root_r   <= '0;
    end else if (cmd.iter) begin
      if (!cy_r[CW-1]) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + tz;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - tz;
      end
      // x*x, then y*y, then their sum, then one root bit per step
      if (cmd.step < STEP_W'(2))
        prod_r <= mop * mop;
      if (cmd.step == STEP_W'(1))
        rem_r <= RW'($unsigned(prod_r));
      else if (cmd.step == STEP_W'(2))
        rem_r <= rem_r + RW'($unsigned(prod_r));
      else if (sq_act) begin
        if (rem_r >= sq_trial) begin
          rem_r  <= rem_r - sq_trial;
          root_r <= (root_r >> 1) + sq_bit;
        end else begin
          root_r <= root_r >> 1;
        end
      end
    end
  end

  // angle: shift to 0..1 turn, clamp, round to ANGLE_BITS; the origin maps to a half turn
  always_comb begin
    zf = z_r + HALF;
    if (zf < 0)
      zc = '0;
    else if (zf[ZW-1:0] > ZW'(FULL))
      zc = FULL;
    else
      zc = zf[32:0];
    zr = {1'b0, zc} + ROUND;
    if (origin_r)
      a_nxt = AW'(1) << (ANGLE_BITS - 1);
    else
      a_nxt = zr[32 -: AW];
  end

  always_comb begin
    if (beam_count == '0)
      n_eff = NW'(1);
    else if (32'(beam_count) > 32'(MAX_BEAMS))
      n_eff = NW'(MAX_BEAMS);
    else
      n_eff = NW'(beam_count);
  end

  assign bfull = mprod_r[ANGLE_BITS +: NW];
  // an angle of exactly a full turn lands on beam n and wraps
  assign bsel  = (bfull >= n_eff) ? '0 : BW'(bfull);

  assign idx_wide = 32'(idx_r);
  assign idx_addr = idx_wide[BW-1:0];
  assign idx_ok   = idx_wide < 32'(MAX_BEAMS);
  assign rd_addr  = cmd.look ? bsel : idx_addr;
  assign upd_we   = !vbit_r || (root_r[RANGE_W-1:0] < rdata_r);

  always_ff @(posedge clk) begin
    if (cmd.ang)
      a_r <= a_nxt;
    if (cmd.mul)
      mprod_r <= PW'(a_r) * PW'(n_eff);
    if (cmd.look) begin
      addr_r <= bsel;
      vbit_r <= valid_r[bsel];
    end else if (cmd.rlook) begin
      vbit_r <= idx_ok && valid_r[idx_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look || cmd.rlook)
      rdata_r <= mem_r[rd_addr];
    if (cmd.upd && upd_we)
      mem_r[addr_r] <= root_r[RANGE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.upd)
        valid_r[addr_r] <= 1'b1;
      if (cmd.rlook && idx_ok)
        valid_r[idx_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (cmd.rd_out)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_out) begin
      out_hit_r   <= vbit_r;
      out_range_r <= (vbit_r && rdata_r < max_range) ? rdata_r : max_range;
    end
  end

  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_beam_range = out_range_r;
  assign out_beam_hit   = out_hit_r;

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_out |=> out_valid_r)
    else $error("read result lost on its way to the output register");

  a_beam_marked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> valid_r[$past(addr_r)])
    else $error("updated beam not marked as hit");
endmodule
`default_nettype wire

/* sv/point_to_polar_beam_min_scan.sv */
`default_nettype none
// Angular beam binning of 2-D points with nearest range per beam. An add item
// (op 0) runs the vectoring CORDIC for the angle, with the squares and the
// bit-serial square root for the range run alongside on the same step counter,
// then rounds the angle, does the beam multiply, reads the beam store and does
// the compare-and-write, and goes back to idle, where the next beat is taken.
// A read item (op 1) looks up the beam and then waits, while the output
// register is still full, until the sink can take the result beat. No new item
// is taken before the last one is done. The hit bits are cleared by reset, so
// the block takes items right after reset with no clearing pass. Configuration
// writes (beam_count at 0x0, max_range at 0x4) belong in idle time only.
module point_to_polar_beam_min_scan #(
  parameter int MAX_BEAMS  = 128,
  parameter int ANGLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pbms_in_if.sink                         in_bus,
  pbms_out_if.source                      out_bus,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pbms_pkg::PADDR_W-1:0]    cfg_paddr,
  input  logic [pbms_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pbms_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import pbms_pkg::*;

  pbms_cmd_t          cmd;
  logic               out_free;
  logic               in_ready;
  logic [COUNT_W-1:0] beam_count;
  logic [RANGE_W-1:0] max_range;

  pbms_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .beam_count (beam_count),
    .max_range  (max_range)
  );

  pbms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_op    (in_bus.op),
    .out_free (out_free),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  assign in_bus.ready = in_ready;

  pbms_dp #(
    .MAX_BEAMS  (MAX_BEAMS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .x              (in_bus.x),
    .y              (in_bus.y),
    .beam_index     (in_bus.beam_index),
    .beam_count     (beam_count),
    .max_range      (max_range),
    .out_valid      (out_bus.valid),
    .out_ready      (out_bus.ready),
    .out_beam_range (out_bus.beam_range),
    .out_beam_hit   (out_bus.beam_hit),
    .out_free       (out_free)
  );
endmodule
`default_nettype wire

/* sim/testbench.sv */
typedef struct packed {
  logic [23:0] beam_range;
  logic        beam_hit;
} beam_reading_t;

class beam_scoreboard;
  logic [7:0]    beam_count;
  logic [23:0]   max_range;
  logic [23:0]   nearest [128];
  bit            filled [128];
  bit            seen [128];     // entry written at least once since reset
  longint        step_angle [30];
  beam_reading_t expected [$];
  int            errors;

  function new();
    beam_count = 8'd120;
    max_range  = 24'd20480;
    errors     = 0;
    foreach (filled[i]) begin
      filled[i]  = 1'b0;
      seen[i]    = 1'b0;
      nearest[i] = '0;
    end
    // atan(2^-i) in 2^-32 turn
    step_angle = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function void set_reg(logic which, logic [31:0] value);
    if (which == pbms_pkg::REG_BEAM_COUNT) beam_count = value[7:0];
    else max_range = value[23:0];
  endfunction

  function longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function int unsigned binary_angle(longint x, longint y);
    longint cx, cy, dx, dy, z, t;
    if (x == 0 && y == 0) return 32'd1 << 15;
    z = 0;
    // fold the left half plane onto the right one
    if (x < 0 && y >= 0) begin
      t = x; x = y; y = -t; z = 64'sh40000000;
    end else if (x < 0) begin
      t = x; x = -y; y = t; z = -64'sh40000000;
    end
    cx = x * 64'sd1073741824;
    cy = y * 64'sd1073741824;
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += step_angle[i];
      end else begin
        cx -= dx; cy += dy; z -= step_angle[i];
      end
    end
    z += 64'sd1 << 31;
    if (z < 0) z = 0;
    if (z > (64'sd1 << 32)) z = 64'sd1 << 32;
    z += 64'sd1 << 15;
    return int'(z >>> 16);
  endfunction

  function void note_input(logic op, logic signed [23:0] x, logic signed [23:0] y,
                           logic [6:0] beam_index);
    longint sx, sy;
    longint unsigned rng;
    int unsigned n, b;
    beam_reading_t want;
    if (op == pbms_pkg::OP_READ) begin
      want.beam_range = max_range;
      want.beam_hit   = 1'b0;
      if (filled[beam_index]) begin
        want.beam_hit = 1'b1;
        if (nearest[beam_index] < max_range) want.beam_range = nearest[beam_index];
      end
      filled[beam_index] = 1'b0;
      expected = {expected, want};
    end else begin
      sx = x;
      sy = y;
      rng = root_floor(sx * sx + sy * sy);
      n = beam_count;
      if (n == 0) n = 1;
      if (n > 128) n = 128;
      b = (binary_angle(sx, sy) * n) >> 16;
      if (b >= n) b = 0;
      if (!filled[b] || rng < nearest[b]) nearest[b] = rng[23:0];
      filled[b] = 1'b1;
      seen[b]   = 1'b1;
    end
  endfunction

  task check(logic [23:0] got_range, logic got_hit);
    beam_reading_t want;
    if (expected.size() == 0) begin
      report($sformatf("beat with nothing pending: range %0d hit %0b", got_range, got_hit));
      return;
    end
    want = expected.pop_front();
    if (got_range !== want.beam_range)
      report($sformatf("beam_range got %0d want %0d", got_range, want.beam_range));
    if (got_hit !== want.beam_hit)
      report($sformatf("beam_hit got %0b want %0b", got_hit, want.beam_hit));
  endtask
endclass

module testbench;
  import pbms_pkg::*;

  localparam logic OP_ADD = ~OP_READ;
  localparam int   LINGER = 48;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [PADDR_W-1:0]    cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  pbms_in_if  in_ch ();
  pbms_out_if out_ch ();

  point_to_polar_beam_min_scan uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_ch),
    .out_bus     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  beam_scoreboard scan;
  bit             steady;  // no idling on either side while set

  always #5 clk = ~clk;

  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic signed [COORD_W-1:0] v;
    v = COORD_W'($urandom);
    return v >>> $urandom_range(0, 23);
  endfunction

  task automatic send(logic op, logic signed [COORD_W-1:0] x,
                      logic signed [COORD_W-1:0] y, logic [IDX_W-1:0] idx);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.op         = op;
    in_ch.x          = x;
    in_ch.y          = y;
    in_ch.beam_index = idx;
    do @(posedge clk); while (!in_ch.ready);
    scan.note_input(op, x, y, idx);
  endtask

  task automatic add_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    send(OP_ADD, x, y, IDX_W'($urandom));
  endtask

  task automatic read_beam(logic [IDX_W-1:0] idx);
    send(OP_READ, rand_coord(), rand_coord(), idx);
  endtask

  // only beams stored at least once are read
  task automatic read_seen();
    int b;
    do b = $urandom_range(0, 127); while (!scan.seen[b]);
    read_beam(IDX_W'(b));
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (scan.expected.size() != 0) @(posedge clk);
  endtask

  // an add beat has no result, so give the datapath time to finish
  task automatic settle();
    drain();
    repeat (LINGER) @(posedge clk);
  endtask

  task automatic write_reg(logic which, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {which, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    scan.set_reg(which, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic configure(logic [COUNT_W-1:0] count, logic [RANGE_W-1:0] limit);
    logic [31:0] noise;
    noise = $urandom;
    settle();
    write_reg(REG_BEAM_COUNT, {noise[23:0], count});
    write_reg(REG_MAX_RANGE, {noise[31:24], limit});
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      if ($urandom_range(0, 39) == 0) steady = !steady;
      if ($urandom_range(0, 99) < 30) read_seen();
      else add_point(rand_coord(), rand_coord());
    end
  endtask

  // result sink
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      scan.check(out_ch.beam_range, out_ch.beam_hit);
    end
  end

  initial begin
    scan             = new();
    steady           = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_ADD;
    in_ch.x          = '0;
    in_ch.y          = '0;
    in_ch.beam_index = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: origin lands mid-turn, the exact half turn wraps to beam 0
    add_point(24'sd0, 24'sd0);
    add_point(-24'sd8388608, 24'sd0);
    add_point(24'sd8388607, 24'sd8388607);
    add_point(-24'sd8388608, -24'sd8388608);
    add_point(24'sd8388607, -24'sd8388608);
    add_point(-24'sd8388608, 24'sd8388607);
    add_point(24'sd1, 24'sd0);
    add_point(24'sd0, -24'sd1);
    read_beam(7'd60);
    read_beam(7'd60);
    read_beam(7'd0);

    configure(8'd128, 24'hFFFFFF);
    // just short of the half turn, top beam
    add_point(-24'sd8388608, 24'sd100000);
    read_beam(7'd127);
    read_beam(7'd127);
    run_random(225);

    configure(8'd0, 24'd0);
    run_random(225);
    configure(8'd255, 24'd30000);
    run_random(225);
    configure(8'd1, 24'd20480);
    run_random(225);
    configure(8'd200, 24'd5000);
    run_random(225);
    configure(COUNT_W'($urandom_range(2, 127)), RANGE_W'($urandom_range(1, 16777214)));
    run_random(225);
    configure(8'd120, 24'd20480);
    run_random(225);

    settle();
    if (scan.errors == 0) begin
      $display("** point_to_polar_beam_min_scan: PASSED **");
    end else begin
      $display("** point_to_polar_beam_min_scan: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d readings outstanding", scan.expected.size());
    $display("** point_to_polar_beam_min_scan: FAILED **");
    $finish;
  end
endmodule

/* files.f */
sv/pbms_pkg.sv
sv/pbms_in_if.sv
sv/pbms_out_if.sv
sv/pbms_regs.sv
sv/pbms_ctrl.sv
sv/pbms_dp.sv
sv/point_to_polar_beam_min_scan.sv
sim/testbench.sv
